// ===== hdl/plane_plane_intersection_unit_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef PLANE_PLANE_INTERSECTION_UNIT_ASSERT_SVH
`define PLANE_PLANE_INTERSECTION_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define PPI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ppi check failed");

// value must hold on the edge after cond
`define PPI_ASSERT_HOLD(lbl, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("ppi held beat changed");

`endif

// ===== hdl/ppi_pkg.sv =====
// ----------------------------------------------------------------------------
// ppi_pkg
// widths, types and the saturating pack shared by the intersection pipeline
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int FW        = 24;   // field width, Q8.16
  localparam int CW        = 49;   // signed cross product and offset vector
  localparam int MW        = 48;   // magnitude of those
  localparam int HW        = 24;   // half of a magnitude
  localparam int PW        = 96;   // wide product magnitude
  localparam int NW        = 98;   // signed numerator
  localparam int DW        = 98;   // squared length of the cross product
  localparam int TW        = 116;  // dividend
  localparam int QW        = 24;   // quotient bits
  localparam int RW        = 124;  // divider remainder
  localparam int FRAC      = 16;
  localparam int NUM_SHIFT = 17;
  localparam int NOPS      = 9;

  localparam logic [FW:0] SAT_POS = 25'h07F_FFFF;
  localparam logic [FW:0] SAT_NEG = 25'h080_0000;
  localparam logic [MW:0] RND_HALF = 49'h0_0000_0000_8000;

  typedef logic signed [FW-1:0] fix_t;

  typedef struct packed {
    logic line_ok;
    fix_t dir_x;
    fix_t dir_y;
    fix_t dir_z;
  } tag_t;

  function automatic fix_t sat_pack(input logic [FW:0] mag, input logic ovf,
                                    input logic neg);
    logic [FW:0] lim;
    logic [FW:0] m;
    logic [FW:0] s;
    lim = neg ? SAT_NEG : SAT_POS;
    m   = (ovf || (mag > lim)) ? lim : mag;
    s   = neg ? (~m + 1'b1) : m;
    return s[FW-1:0];
  endfunction

endpackage

// ===== hdl/ppi_in_if.sv =====
// ----------------------------------------------------------------------------
// ppi_in_if
// plane pair channel: two normals and two offsets per beat
// ----------------------------------------------------------------------------
interface ppi_in_if import ppi_pkg::*; ();
  logic valid;
  logic ready;
  fix_t first_normal_x;
  fix_t first_normal_y;
  fix_t first_normal_z;
  fix_t first_offset;
  fix_t second_normal_x;
  fix_t second_normal_y;
  fix_t second_normal_z;
  fix_t second_offset;

  modport source(output valid, first_normal_x, first_normal_y, first_normal_z,
                 first_offset, second_normal_x, second_normal_y, second_normal_z,
                 second_offset, input ready);
  modport sink(input valid, first_normal_x, first_normal_y, first_normal_z,
               first_offset, second_normal_x, second_normal_y, second_normal_z,
               second_offset, output ready);
endinterface

// ===== hdl/ppi_out_if.sv =====
// ----------------------------------------------------------------------------
// ppi_out_if
// line channel: point, direction and line flag per beat
// ----------------------------------------------------------------------------
interface ppi_out_if import ppi_pkg::*; ();
  logic valid;
  logic ready;
  fix_t point_x;
  fix_t point_y;
  fix_t point_z;
  fix_t direction_x;
  fix_t direction_y;
  fix_t direction_z;
  logic line_valid;

  modport source(output valid, point_x, point_y, point_z, direction_x,
                 direction_y, direction_z, line_valid, input ready);
  modport sink(input valid, point_x, point_y, point_z, direction_x,
               direction_y, direction_z, line_valid, output ready);
endinterface

// ===== hdl/ppi_front.sv =====
// ----------------------------------------------------------------------------
// ppi_front
// two stages: 24x24 products, then cross product and offset vector
// ----------------------------------------------------------------------------
module ppi_front import ppi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  fix_t                n1_i [3],
  input  fix_t                n2_i [3],
  input  fix_t                d1_i,
  input  fix_t                d2_i,
  output logic                out_vld,
  output logic signed [CW-1:0] c_o [3],
  output logic signed [CW-1:0] a_o [3]
);

  logic va_r, vb_r;
  logic signed [2*FW-1:0] pp_r [3];
  logic signed [2*FW-1:0] pm_r [3];
  logic signed [2*FW-1:0] pa_r [3];
  logic signed [2*FW-1:0] pb_r [3];
  logic signed [CW-1:0]   c_r  [3];
  logic signed [CW-1:0]   a_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_vld;
      vb_r <= va_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    localparam int J = (k + 1) % 3;
    localparam int L = (k + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        pp_r[k] <= n1_i[J] * n2_i[L];
        pm_r[k] <= n1_i[L] * n2_i[J];
        pa_r[k] <= d2_i * n1_i[k];
        pb_r[k] <= d1_i * n2_i[k];
        c_r[k]  <= CW'(pp_r[k]) - CW'(pm_r[k]);
        a_r[k]  <= CW'(pa_r[k]) - CW'(pb_r[k]);
      end
    end
    assign c_o[k] = c_r[k];
    assign a_o[k] = a_r[k];
  end

  assign out_vld = vb_r;

endmodule

// ===== hdl/ppi_numer.sv =====
// ----------------------------------------------------------------------------
// ppi_numer
// six stages: split products, numerators, squared length, dividend set-up
// ----------------------------------------------------------------------------
module ppi_numer import ppi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] c_i [3],
  input  logic signed [CW-1:0] a_i [3],
  output logic                 out_vld,
  output logic [TW-1:0]        t_o [3],
  output logic                 neg_o [3],
  output logic [DW:0]          den2_o,
  output tag_t                 tag_o
);

  localparam int NST = 6;

  logic [MW-1:0] cmag [3];
  logic [MW-1:0] amag [3];
  logic          csgn [3];
  logic          asgn [3];
  logic [MW-1:0] opx [NOPS];
  logic [MW-1:0] opy [NOPS];
  logic          osg [NOPS];
  fix_t          dir_nxt [3];
  tag_t          tag_nxt;

  logic          v_r [NST];
  tag_t          tag_r [NST];
  logic [2*HW-1:0] pll_r [NOPS];
  logic [2*HW-1:0] plh_r [NOPS];
  logic [2*HW-1:0] phl_r [NOPS];
  logic [2*HW-1:0] phh_r [NOPS];
  logic          sgc_r [NOPS];
  logic [PW-1:0] prod_r [NOPS];
  logic          sgd_r [NOPS];
  logic signed [PW:0] sp_r [6];
  logic [DW-1:0] dete_r, detf_r, detg_r;
  logic signed [NW-1:0] num_r [3];
  logic [NW-2:0] mag_r [3];
  logic          negg_r [3];
  logic          negh_r [3];
  logic [TW-1:0] t_r [3];
  logic [DW:0]   den2_r;

  for (genvar k = 0; k < 3; k++) begin : g_op
    localparam int J = (k + 1) % 3;
    localparam int L = (k + 2) % 3;
    logic [MW:0] rnd;
    assign csgn[k] = c_i[k][CW-1];
    assign asgn[k] = a_i[k][CW-1];
    assign cmag[k] = csgn[k] ? MW'(-c_i[k]) : MW'(c_i[k]);
    assign amag[k] = asgn[k] ? MW'(-a_i[k]) : MW'(a_i[k]);
    // num[k] = a[j]*c[l] - a[l]*c[j]
    assign opx[2*k]   = amag[J];
    assign opy[2*k]   = cmag[L];
    assign osg[2*k]   = asgn[J] ^ csgn[L];
    assign opx[2*k+1] = amag[L];
    assign opy[2*k+1] = cmag[J];
    assign osg[2*k+1] = asgn[L] ^ csgn[J];
    assign opx[6+k]   = cmag[k];
    assign opy[6+k]   = cmag[k];
    assign osg[6+k]   = 1'b0;
    // direction: Q16.32 to Q8.16, round half away from zero
    assign rnd        = {1'b0, cmag[k]} + RND_HALF;
    assign dir_nxt[k] = sat_pack(rnd[FRAC+FW:FRAC], |rnd[MW:FRAC+FW+1], csgn[k]);
  end

  always_comb begin
    tag_nxt.line_ok = (c_i[0] != '0) || (c_i[1] != '0) || (c_i[2] != '0);
    tag_nxt.dir_x   = dir_nxt[0];
    tag_nxt.dir_y   = dir_nxt[1];
    tag_nxt.dir_z   = dir_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
      for (int s = 1; s < NST; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= tag_nxt;
      for (int s = 1; s < NST; s++) tag_r[s] <= tag_r[s-1];
      for (int i = 0; i < NOPS; i++) begin
        pll_r[i]  <= opx[i][HW-1:0]  * opy[i][HW-1:0];
        plh_r[i]  <= opx[i][HW-1:0]  * opy[i][MW-1:HW];
        phl_r[i]  <= opx[i][MW-1:HW] * opy[i][HW-1:0];
        phh_r[i]  <= opx[i][MW-1:HW] * opy[i][MW-1:HW];
        sgc_r[i]  <= osg[i];
        prod_r[i] <= (PW'(phh_r[i]) << (2*HW))
                   + ((PW'(plh_r[i]) + PW'(phl_r[i])) << HW)
                   + PW'(pll_r[i]);
        sgd_r[i]  <= sgc_r[i];
      end
      for (int i = 0; i < 6; i++) begin
        sp_r[i] <= sgd_r[i] ? -$signed({1'b0, prod_r[i]}) : $signed({1'b0, prod_r[i]});
      end
      dete_r <= DW'(prod_r[6]) + DW'(prod_r[7]) + DW'(prod_r[8]);
      detf_r <= dete_r;
      detg_r <= detf_r;
      for (int k = 0; k < 3; k++) begin
        num_r[k]  <= NW'(sp_r[2*k]) - NW'(sp_r[2*k+1]);
        negg_r[k] <= num_r[k][NW-1];
        mag_r[k]  <= num_r[k][NW-1] ? (NW-1)'(-num_r[k]) : (NW-1)'(num_r[k]);
        negh_r[k] <= negg_r[k];
        t_r[k]    <= (TW'(mag_r[k]) << NUM_SHIFT) + TW'(detg_r);
      end
      den2_r <= {detg_r, 1'b0};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_out
    assign t_o[k]   = t_r[k];
    assign neg_o[k] = negh_r[k];
  end

  assign den2_o  = den2_r;
  assign tag_o   = tag_r[NST-1];
  assign out_vld = v_r[NST-1];

endmodule

// ===== hdl/ppi_div.sv =====
// ----------------------------------------------------------------------------
// ppi_div
// pipelined restoring divider, three lanes sharing one divisor, one
// quotient bit per stage plus an overflow check up front
// ----------------------------------------------------------------------------
module ppi_div import ppi_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [TW-1:0] t_i [3],
  input  logic          neg_i [3],
  input  logic [DW:0]   den2_i,
  input  tag_t          tag_i,
  output logic          out_vld,
  output logic [QW-1:0] q_o [3],
  output logic          ovf_o [3],
  output logic          neg_o [3],
  output tag_t          tag_o
);

  logic          v_r   [QW+1];
  tag_t          tag_r [QW+1];
  logic [RW-1:0] rem_r [QW][3];
  logic [DW:0]   den_r [QW];
  logic [QW-1:0] q_r   [QW+1][3];
  logic          ovf_r [QW+1][3];
  logic          neg_r [QW+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= QW; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
      for (int s = 1; s <= QW; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [RW-1:0] dsh;
    logic [RW:0]   diff;
    if (en) begin
      tag_r[0] <= tag_i;
      den_r[0] <= den2_i;
      for (int k = 0; k < 3; k++) begin
        rem_r[0][k] <= RW'(t_i[k]);
        q_r[0][k]   <= '0;
        // quotient would not fit in the field
        ovf_r[0][k] <= RW'(t_i[k]) >= (RW'(den2_i) << QW);
        neg_r[0][k] <= neg_i[k];
      end
      for (int s = 1; s <= QW; s++) begin
        tag_r[s] <= tag_r[s-1];
        if (s < QW) den_r[s] <= den_r[s-1];
        for (int k = 0; k < 3; k++) begin
          dsh  = RW'(den_r[s-1]) << (QW - s);
          diff = {1'b0, rem_r[s-1][k]} - {1'b0, dsh};
          q_r[s][k]   <= {q_r[s-1][k][QW-2:0], ~diff[RW]};
          ovf_r[s][k] <= ovf_r[s-1][k];
          neg_r[s][k] <= neg_r[s-1][k];
          if (s < QW) rem_r[s][k] <= diff[RW] ? rem_r[s-1][k] : diff[RW-1:0];
        end
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_out
    assign q_o[k]   = q_r[QW][k];
    assign ovf_o[k] = ovf_r[QW][k];
    assign neg_o[k] = neg_r[QW][k];
  end

  assign tag_o   = tag_r[QW];
  assign out_vld = v_r[QW];

endmodule

// ===== hdl/plane_plane_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// plane_plane_intersection_unit
// intersection line of two planes in Q8.16; while the output is not stalled, one plane pair per clock
// ----------------------------------------------------------------------------
// in_ch carries one plane pair per beat: two normals and two offsets, Q8.16.
// out_ch returns one beat per pair: the point on the line closest to the
// origin, the unnormalized cross product as direction and line_valid.
// parallel planes (zero cross product) give line_valid low and a zero point.
// all outputs round to nearest, ties away from zero, and saturate.
// an accepted input beat becomes its output beat after passing through
// 2 product/cross stages, 6 stages of split 48x48 products and dividend
// set-up, 25 divider stages (an overflow check, then one quotient bit each) and
// the output register.
// throughput is one beat per clock; the whole pipeline advances whenever the
// output register is empty or being taken, so in_ch.ready is low only while
// a finished beat waits on a stalled receiver, and nothing is dropped.
// reset clears every stage valid bit; the unit takes input in the first
// cycle after reset.
// ----------------------------------------------------------------------------
module plane_plane_intersection_unit import ppi_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ppi_in_if.sink    in_ch,
  ppi_out_if.source out_ch
);

  logic                 adv;
  fix_t                 n1 [3];
  fix_t                 n2 [3];
  logic                 fr_vld;
  logic signed [CW-1:0] fr_c [3];
  logic signed [CW-1:0] fr_a [3];
  logic                 nm_vld;
  logic [TW-1:0]        nm_t [3];
  logic                 nm_neg [3];
  logic [DW:0]          nm_den2;
  tag_t                 nm_tag;
  logic                 dv_vld;
  logic [QW-1:0]        dv_q [3];
  logic                 dv_ovf [3];
  logic                 dv_neg [3];
  tag_t                 dv_tag;
  fix_t                 pt_nxt [3];

  logic out_valid_r;
  fix_t pt_r [3];
  tag_t tag_r;

  // pipeline moves unless a finished beat is stuck
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign n1[0] = in_ch.first_normal_x;
  assign n1[1] = in_ch.first_normal_y;
  assign n1[2] = in_ch.first_normal_z;
  assign n2[0] = in_ch.second_normal_x;
  assign n2[1] = in_ch.second_normal_y;
  assign n2[2] = in_ch.second_normal_z;

  ppi_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_ch.valid),
    .n1_i    (n1),
    .n2_i    (n2),
    .d1_i    (in_ch.first_offset),
    .d2_i    (in_ch.second_offset),
    .out_vld (fr_vld),
    .c_o     (fr_c),
    .a_o     (fr_a)
  );

  ppi_numer u_numer (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (fr_vld),
    .c_i     (fr_c),
    .a_i     (fr_a),
    .out_vld (nm_vld),
    .t_o     (nm_t),
    .neg_o   (nm_neg),
    .den2_o  (nm_den2),
    .tag_o   (nm_tag)
  );

  ppi_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (nm_vld),
    .t_i     (nm_t),
    .neg_i   (nm_neg),
    .den2_i  (nm_den2),
    .tag_i   (nm_tag),
    .out_vld (dv_vld),
    .q_o     (dv_q),
    .ovf_o   (dv_ovf),
    .neg_o   (dv_neg),
    .tag_o   (dv_tag)
  );

  for (genvar k = 0; k < 3; k++) begin : g_pt
    assign pt_nxt[k] = dv_tag.line_ok ? sat_pack({1'b0, dv_q[k]}, dv_ovf[k], dv_neg[k])
                                      : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt_r  <= pt_nxt;
      tag_r <= dv_tag;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.point_x     = pt_r[0];
  assign out_ch.point_y     = pt_r[1];
  assign out_ch.point_z     = pt_r[2];
  assign out_ch.direction_x = tag_r.dir_x;
  assign out_ch.direction_y = tag_r.dir_y;
  assign out_ch.direction_z = tag_r.dir_z;
  assign out_ch.line_valid  = tag_r.line_ok;

endmodule

// ===== hdl/ppi_checker.sv =====
// ----------------------------------------------------------------------------
// ppi_checker
// port-level checks on the intersection unit, bound to the top level
// ----------------------------------------------------------------------------
`include "plane_plane_intersection_unit_assert.svh"

module ppi_checker import ppi_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input fix_t point_x,
  input fix_t point_y,
  input fix_t point_z,
  input fix_t direction_x,
  input fix_t direction_y,
  input fix_t direction_z,
  input logic line_valid
);

  logic [6*FW:0] beat;
  logic          stalled;
  logic          pt_zero;
  logic          dir_zero;

  assign beat     = {point_x, point_y, point_z, direction_x, direction_y,
                     direction_z, line_valid};
  assign stalled  = out_valid && !out_ready;
  assign pt_zero  = (point_x == '0) && (point_y == '0) && (point_z == '0);
  assign dir_zero = (direction_x == '0) && (direction_y == '0) && (direction_z == '0);

  `PPI_ASSERT(a_valid_holds, stalled |=> out_valid)
  `PPI_ASSERT_HOLD(a_beat_holds, stalled, beat)
  `PPI_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)
  `PPI_ASSERT(a_parallel_point_zero, out_valid && !line_valid |-> pt_zero)
  `PPI_ASSERT(a_parallel_dir_zero, out_valid && !line_valid |-> dir_zero)

endmodule

bind plane_plane_intersection_unit ppi_checker u_ppi_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .point_x     (out_ch.point_x),
  .point_y     (out_ch.point_y),
  .point_z     (out_ch.point_z),
  .direction_x (out_ch.direction_x),
  .direction_y (out_ch.direction_y),
  .direction_z (out_ch.direction_z),
  .line_valid  (out_ch.line_valid)
);
